@@ hdl/p2ba_pkg.sv @@
// Shared types and codes for the power-of-two bin allocator.
// Self-contained; imported by the top level.
package p2ba_pkg;

  localparam int SIZE_W = 17;
  localparam int ADDR_W = 16;
  localparam int STAT_W = 2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_REUSED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FRESH  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OOM    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FREED  = 2'd3;

  localparam logic [SIZE_W-1:0] HEAP_LIMIT_RESET = 17'h10000;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } p2ba_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [SIZE_W-1:0] granted_size;
    logic [STAT_W-1:0] status;
  } p2ba_out_t;

endpackage

@@ hdl/power_of_two_bin_allocator_unit.sv @@
// Top level of the power-of-two bin allocator: request decode, bin heads,
// bump pointer and free-list sequencing. Depends on p2ba_pkg and p2ba_ram.
//
// Channel  Direction  Handshake                    Payload
// in_      input      start high while busy low    in_req     (p2ba_in_t)
// out_     output     out_strobe, one cycle        out_result (p2ba_out_t)
// cfg_     input      cfg_valid and cfg_ready      cfg_data   (heap limit)
//
// Each transaction: the accept edge issues the read of the link memory at
// the bin head, and the write-back in the busy state stores the head, the
// link word and the bump pointer and registers the result. The result is
// shown in the cycle after that, when a new request may already be accepted.
// busy is high only in the cycle between accept and write-back. Reset is
// synchronous, clears the bin occupancy flags and bump pointer and restores
// the limit; the link memory and the bin heads need no clearing. The receiver
// cannot stall, so nothing waits on the output side.
module power_of_two_bin_allocator_unit #(
  parameter int HEAP_BYTES    = 65536,
  parameter int BIN_COUNT     = 16,
  parameter int GRANULE_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  p2ba_pkg::p2ba_in_t            in_req,
  output logic                          out_strobe,
  output p2ba_pkg::p2ba_out_t           out_result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [p2ba_pkg::SIZE_W-1:0]   cfg_data
);

  import p2ba_pkg::*;

  // Granule size is taken to be a power of two.
  localparam int GRAN_SH  = $clog2(GRANULE_BYTES);
  localparam int GRANULES = HEAP_BYTES / GRANULE_BYTES;
  localparam int HEAD_W   = $clog2(GRANULES);
  localparam int LINK_W   = HEAD_W + 1;
  localparam int IDX_W    = ADDR_W - GRAN_SH;
  localparam int BIN_W    = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int HEAP_W   = $clog2(HEAP_BYTES + 1);
  localparam int CMP_W    = (HEAP_W > SIZE_W) ? HEAP_W : SIZE_W;
  localparam int RADR_W   = HEAD_W + GRAN_SH;
  localparam int BINV_W   = 5;
  localparam int GRNT_W   = SIZE_W + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  // ---------------------------------------------------------------- registers
  logic                    state_r, state_nxt;
  logic [SIZE_W-1:0]       heap_limit_r;
  logic [SIZE_W-1:0]       bump_r, bump_nxt;
  logic [BIN_COUNT-1:0]    nonempty_r, nonempty_nxt;
  logic [HEAD_W-1:0]       head_r [BIN_COUNT];
  logic                    out_strobe_r;
  p2ba_out_t               out_r, out_nxt;

  // request captured at accept
  logic                    act_r;
  logic [ADDR_W-1:0]       addr_r;
  logic [BIN_W-1:0]        bin_r;
  logic                    over_r;
  logic [GRNT_W-1:0]       grant_r;

  // -------------------------------------------------------------- size decode
  logic [SIZE_W-1:0]       size_c;
  logic [SIZE_W-1:0]       size_m1;
  logic [BINV_W-1:0]       bin_val;
  logic [BIN_W-1:0]        bin_idx;
  logic                    over_in;
  logic [GRNT_W-1:0]       grant_in;
  logic                    accept;

  always_comb begin
    size_c  = (in_req.request_size < SIZE_W'(GRANULE_BYTES)) ?
              SIZE_W'(GRANULE_BYTES) : in_req.request_size;
    size_m1 = size_c - SIZE_W'(1);
    bin_val = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size_m1[i]) begin
        bin_val = BINV_W'(i);
      end
    end
    bin_idx  = BIN_W'(bin_val);
    over_in  = (32'(bin_val) >= BIN_COUNT);
    grant_in = GRNT_W'(1) << (bin_val + BINV_W'(1));
  end

  assign accept = start && (state_r == S_IDLE);

  // ---------------------------------------------------------- link memory
  logic              ram_we;
  logic [HEAD_W-1:0] ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  p2ba_ram #(
    .WIDTH (LINK_W),
    .DEPTH (GRANULES)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (accept),
    .rd_addr (head_r[bin_idx]),
    .rd_data (ram_rdata)
  );

  // ------------------------------------------------------------- write-back
  logic [SIZE_W-1:0] eff_limit;
  logic [GRNT_W:0]   bump_sum;
  logic [IDX_W-1:0]  free_idx;
  logic              free_in_heap;
  logic [HEAD_W-1:0] head_cur;
  logic              head_we;
  logic [HEAD_W-1:0] head_wdata;
  logic [RADR_W-1:0] reuse_addr;

  always_comb begin
    eff_limit    = (CMP_W'(heap_limit_r) < CMP_W'(HEAP_BYTES)) ?
                   heap_limit_r : SIZE_W'(HEAP_BYTES);
    bump_sum     = (GRNT_W + 1)'(bump_r) + (GRNT_W + 1)'(grant_r);
    free_idx     = addr_r[ADDR_W-1:GRAN_SH];
    free_in_heap = (32'(free_idx) < GRANULES);
    head_cur     = head_r[bin_r];
    reuse_addr   = {head_cur, {GRAN_SH{1'b0}}};

    state_nxt    = state_r;
    bump_nxt     = bump_r;
    nonempty_nxt = nonempty_r;
    head_we      = 1'b0;
    head_wdata   = ram_rdata[HEAD_W-1:0];
    ram_we       = 1'b0;
    ram_waddr    = HEAD_W'(free_idx);
    ram_wdata    = nonempty_r[bin_r] ? {1'b1, head_cur} : '0;
    out_nxt      = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_BUSY;
        end
      end
      S_BUSY: begin
        state_nxt = S_IDLE;
        out_nxt.granted_size = over_r ? '0 : grant_r[SIZE_W-1:0];
        if (act_r == ACT_ALLOC) begin
          out_nxt.result_address = '0;
          out_nxt.status         = ST_OOM;
          if (!over_r) begin
            if (nonempty_r[bin_r]) begin
              // Pop the head; the link word says whether a successor exists.
              out_nxt.result_address = ADDR_W'(reuse_addr);
              out_nxt.status         = ST_REUSED;
              if (ram_rdata[LINK_W-1]) begin
                head_we = 1'b1;
              end else begin
                nonempty_nxt[bin_r] = 1'b0;
              end
            end else if (bump_sum <= (GRNT_W + 1)'(eff_limit)) begin
              out_nxt.result_address = bump_r[ADDR_W-1:0];
              out_nxt.status         = ST_FRESH;
              bump_nxt               = bump_sum[SIZE_W-1:0];
            end
          end
        end else begin
          out_nxt.result_address = {free_idx, {GRAN_SH{1'b0}}};
          out_nxt.status         = ST_FREED;
          if (!over_r && free_in_heap) begin
            ram_we              = 1'b1;
            head_we             = 1'b1;
            head_wdata          = HEAD_W'(free_idx);
            nonempty_nxt[bin_r] = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      heap_limit_r <= HEAP_LIMIT_RESET;
      bump_r       <= '0;
      nonempty_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bump_r       <= bump_nxt;
      nonempty_r   <= nonempty_nxt;
      out_strobe_r <= (state_r == S_BUSY);
      if (cfg_valid && cfg_ready) begin
        heap_limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      act_r   <= in_req.action;
      addr_r  <= in_req.block_address;
      bin_r   <= bin_idx;
      over_r  <= over_in;
      grant_r <= grant_in;
    end
    if (head_we) begin
      head_r[bin_r] <= head_wdata;
    end
  end

  assign busy       = (state_r == S_BUSY);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

  // --------------------------------------------------------------- checks
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted transaction did not enter the busy cycle");

  a_busy_single : assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && out_strobe))
    else $error("write-back did not finish in one cycle with a result");

  a_strobe_src : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a preceding write-back cycle");

  a_no_link_write_alloc : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (busy && act_r == ACT_FREE))
    else $error("link memory written outside a free");

endmodule

@@ hdl/p2ba_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module p2ba_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 8192
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
